>>> hdl/dts_pkg.sv
// shared types and constants for the drum trigger step sequencer
package dts_pkg;

  localparam int SONG_DEPTH_DEF = 1024;
  localparam int CHANNELS_DEF   = 16;

  localparam logic [3:0] K_NONE    = 4'd0;
  localparam logic [3:0] K_TOGGLE  = 4'd1;
  localparam logic [3:0] K_MEASURE = 4'd2;
  localparam logic [3:0] K_GROUP   = 4'd3;
  localparam logic [3:0] K_LAST    = 4'd4;
  localparam logic [3:0] K_COPY    = 4'd5;
  localparam logic [3:0] K_PASTE   = 4'd6;
  localparam logic [3:0] K_CLEAR   = 4'd7;
  localparam logic [3:0] K_REC     = 4'd8;
  localparam logic [3:0] K_SONG    = 4'd9;
  localparam logic [3:0] K_APPEND  = 4'd10;
  localparam logic [3:0] K_REMOVE  = 4'd11;
  localparam logic [3:0] K_LOOP    = 4'd12;
  localparam logic [3:0] K_PLAY    = 4'd13;
  localparam logic [3:0] K_FASTER  = 4'd14;
  localparam logic [3:0] K_SLOWER  = 4'd15;

  localparam logic [1:0] CFG_EXT   = 2'd0;
  localparam logic [1:0] CFG_PHASE = 2'd1;
  localparam logic [1:0] CFG_TRIG  = 2'd2;

  localparam logic [1:0] SONG_IDLE = 2'd0;
  localparam logic [1:0] SONG_REC  = 2'd1;
  localparam logic [1:0] SONG_PLAY = 2'd2;

  localparam logic [4:0] TEMPO_TOP = 5'd29;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] button_index;
    logic       ext_step_edge;
    logic       reset_edge;
  } in_item_t;

  typedef struct packed {
    logic [15:0] trigger_gates;
    logic [3:0]  step_pos;
    logic        step_light_on;
    logic [3:0]  measure_sel;
    logic [1:0]  group_sel;
    logic [3:0]  last_step;
    logic [1:0]  song_mode;
    logic [9:0]  display_value;
    logic        running;
    logic        loop_on;
  } out_item_t;

  function automatic logic [9:0] bpm_of(input logic [4:0] idx);
    logic [9:0] v;
    case (idx)
      5'd0: v = 10'd30;   5'd1: v = 10'd31;   5'd2: v = 10'd32;   5'd3: v = 10'd33;
      5'd4: v = 10'd34;   5'd5: v = 10'd36;   5'd6: v = 10'd37;   5'd7: v = 10'd39;
      5'd8: v = 10'd40;   5'd9: v = 10'd42;   5'd10: v = 10'd45;  5'd11: v = 10'd27;
      5'd12: v = 10'd50;  5'd13: v = 10'd52;  5'd14: v = 10'd56;  5'd15: v = 10'd60;
      5'd16: v = 10'd64;  5'd17: v = 10'd69;  5'd18: v = 10'd75;  5'd19: v = 10'd81;
      5'd20: v = 10'd90;  5'd21: v = 10'd100; 5'd22: v = 10'd112; 5'd23: v = 10'd128;
      5'd24: v = 10'd150; 5'd25: v = 10'd180; 5'd26: v = 10'd225; 5'd27: v = 10'd300;
      5'd28: v = 10'd450; default: v = 10'd900;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/dts_pattern_mem.sv
// pattern store: 64 pages of 16 rows of 16 channel bits, row-wide access
module dts_pattern_mem (
  input  logic        clk,
  input  logic        we,
  input  logic [9:0]  waddr,
  input  logic [15:0] wdata,
  input  logic [9:0]  raddr,
  output logic [15:0] rdata
);
  logic [15:0] mem [1024];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/dts_song_mem.sv
// song list memory of measure and group entries
module dts_song_mem #(
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [5:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [5:0]    rdata
);
  logic [5:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/drum_trigger_step_sequencer.sv
// Drum trigger step sequencer top level. One input item is one audio sample; it
// produces one result item. After acceptance an item passes S_RD, S_EV and S_DONE;
// a copy, paste or clear also passes S_PAGE, which walks the 16 page rows with one
// extra step for the last row's read. After reset a clearing pass sweeps the
// pattern memory while no item is accepted. The state sequence follows from the
// row-wide access of the pattern memory and the registered read of the song list
// memory. A result waits in an output register and the next item is taken while it
// waits; a further finished item holds the input until that register frees up.
module drum_trigger_step_sequencer #(
  parameter int SONG_DEPTH = dts_pkg::SONG_DEPTH_DEF,
  parameter int CHANNELS   = dts_pkg::CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dts_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dts_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  localparam int SW = $clog2(SONG_DEPTH);
  localparam int LW = $clog2(SONG_DEPTH + 1);
  localparam logic [LW-1:0] LEN_MAX = LW'(SONG_DEPTH - 1);
  localparam logic [15:0] CH_MASK = 16'((32'd1 << CHANNELS) - 1);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EV   = 3'd3;
  localparam logic [2:0] S_PAGE = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] st_r, st_nxt;
  logic       ext_mode_r;
  logic [23:0] ppb_r;
  logic [7:0]  trig_r;

  dts_pkg::in_item_t it_r;
  logic [LW-1:0] song_len_r, play_pos_r;
  logic [1:0]  song_st_r;
  logic        loop_r, run_r, pend_r;
  logic [4:0]  tempo_r;
  logic [32:0] phase_r;
  logic [5:0]  tick_r;
  logic [3:0]  step_r, wrap_r, meas_r;
  logic [1:0]  grp_r;
  logic [7:0]  cnt_r [16];
  logic        adv_r, ld_r;
  logic [9:0]  clr_r;
  logic [4:0]  row_r;
  logic [15:0] copy_r [16];
  logic [33:0] inc_r;
  logic        ov_valid_r;
  logic        it_pend_r;
  dts_pkg::out_item_t ov_r;

  logic        pm_we;
  logic [9:0]  pm_wa, pm_ra;
  logic [15:0] pm_wd, pm_rd;
  logic        sm_we;
  logic [SW-1:0] sm_wa, sm_ra;
  logic [5:0]  sm_wd, sm_rd;

  dts_pattern_mem u_pm (.clk, .we(pm_we), .waddr(pm_wa), .wdata(pm_wd),
                        .raddr(pm_ra), .rdata(pm_rd));
  dts_song_mem #(.AW(SW)) u_sm (.clk, .we(sm_we), .waddr(sm_wa), .wdata(sm_wd),
                                .raddr(sm_ra), .rdata(sm_rd));

  logic res_wr;
  assign res_wr = (st_r == S_IDLE) && it_pend_r && (!ov_valid_r || out_ready);

  assign cfg_ready = 1'b1;
  assign in_ready  = (st_r == S_IDLE) && (!it_pend_r || !ov_valid_r || out_ready);
  assign out_valid = ov_valid_r;
  assign out_data  = ov_r;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  logic [9:0] bpm;
  assign bpm = dts_pkg::bpm_of(tempo_r);

  // tempo and phase step as they stand after this cycle
  logic [4:0]  tempo_nx;
  logic [23:0] ppb_nx;
  always_comb begin
    tempo_nx = tempo_r;
    if (st_r == S_DONE) begin
      if (it_r.kind == dts_pkg::K_FASTER && tempo_r < dts_pkg::TEMPO_TOP)
        tempo_nx = tempo_r + 5'd1;
      else if (it_r.kind == dts_pkg::K_SLOWER && tempo_r != 5'd0)
        tempo_nx = tempo_r - 5'd1;
    end
    ppb_nx = ppb_r;
    if (cfg_valid && cfg_ready && cfg_index == dts_pkg::CFG_PHASE) ppb_nx = cfg_data;
  end

  logic is_page;
  assign is_page = it_r.kind == dts_pkg::K_COPY || it_r.kind == dts_pkg::K_PASTE ||
                   it_r.kind == dts_pkg::K_CLEAR;

  // tempo and step decision at acceptance
  logic [32:0] ph_n;
  logic [5:0]  tk_n;
  logic        pd_n, adv_n;
  logic [34:0] ph_sum;
  always_comb begin
    ph_n = phase_r; tk_n = tick_r; pd_n = pend_r;
    ph_sum = {2'b0, phase_r} + {1'b0, inc_r};
    if (!ext_mode_r) begin
      if (run_r) begin
        if (ph_sum >= 35'h100000000) begin
          tk_n = (tick_r == 6'd47) ? 6'd0 : tick_r + 6'd1;
          ph_sum = ph_sum - 35'h100000000;
          if (tk_n == 6'd0 || tk_n == 6'd3 || tk_n == 6'd6 || tk_n == 6'd9 ||
              tk_n == 6'd12 || tk_n == 6'd15 || tk_n == 6'd18 || tk_n == 6'd21 ||
              tk_n == 6'd24 || tk_n == 6'd27 || tk_n == 6'd30 || tk_n == 6'd33 ||
              tk_n == 6'd36 || tk_n == 6'd39 || tk_n == 6'd42 || tk_n == 6'd45)
            pd_n = 1'b1;
        end
        ph_n = (ph_sum > 35'h1FFFFFFFF) ? 33'h1FFFFFFFF : ph_sum[32:0];
      end else begin
        tk_n = 6'd47; ph_n = 33'h100000000; pd_n = 1'b0;
      end
    end
    if (in_data.reset_edge) begin
      tk_n = 6'd47; ph_n = 33'h100000000;
    end
    adv_n = (in_data.ext_step_edge && ext_mode_r) || pd_n;
    if (adv_n) pd_n = 1'b0;
  end

  logic [3:0] step_in;
  assign step_in = in_data.reset_edge ? 4'd0 : step_r;
  logic [LW-1:0] pos_in;
  assign pos_in = in_data.reset_edge ? '0 : play_pos_r;

  // advance outcome in S_RD (uses pm_rd row of old step)
  logic [LW-1:0] pos_adv;
  logic song_end_stop, song_load;
  always_comb begin
    pos_adv = play_pos_r; song_end_stop = 1'b0; song_load = 1'b0;
    if (adv_r && step_r >= wrap_r && song_st_r == dts_pkg::SONG_PLAY) begin
      if ({1'b0, play_pos_r} + 1'b1 < {1'b0, song_len_r}) begin
        pos_adv = play_pos_r + 1'b1; song_load = 1'b1;
      end else if (!loop_r) song_end_stop = 1'b1;
      else begin
        pos_adv = '0; song_load = 1'b1;
      end
    end
  end

  logic [3:0] st_i, ch_i;
  assign st_i = it_r.button_index[7:4];
  assign ch_i = it_r.button_index[3:0];
  logic [15:0] tog_row;
  always_comb begin
    tog_row = pm_rd;
    if (pm_rd[ch_i]) tog_row[ch_i] = 1'b0;
    else begin
      tog_row = tog_row & ~(16'hF << {ch_i[3:2], 2'b00});
      tog_row[ch_i] = 1'b1;
    end
  end

  always_comb begin
    st_nxt = st_r;
    pm_we = 1'b0; pm_wa = clr_r; pm_wd = '0;
    pm_ra = {grp_r, meas_r, step_r};
    sm_we = 1'b0;
    sm_wa = SW'(song_len_r);
    sm_wd = {grp_r, meas_r};
    sm_ra = SW'(pos_adv);
    unique case (st_r)
      S_CLR: begin
        pm_we = 1'b1;
        if (clr_r == 10'd1023) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        pm_ra = {grp_r, meas_r, step_in};
        if (in_acc) st_nxt = S_RD;
      end
      S_RD: st_nxt = S_EV;
      S_EV: begin
        // page of the panel event follows a song entry loaded by this item's step
        if (ld_r) pm_ra = {sm_rd[5:4], sm_rd[3:0], st_i};
        else pm_ra = {grp_r, meas_r, st_i};
        if (it_r.kind == dts_pkg::K_APPEND && song_st_r == dts_pkg::SONG_REC)
          sm_we = 1'b1;
        sm_ra = '0;
        st_nxt = is_page ? S_PAGE : S_DONE;
      end
      S_PAGE: begin
        pm_ra = {grp_r, meas_r, row_r[3:0]};
        pm_wa = {grp_r, meas_r, row_r[3:0]};
        if (it_r.kind == dts_pkg::K_PASTE) begin
          pm_we = 1'b1; pm_wd = copy_r[row_r[3:0]];
        end else if (it_r.kind == dts_pkg::K_CLEAR) pm_we = 1'b1;
        if (row_r == 5'd16) begin
          pm_we = 1'b0; st_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (it_r.kind == dts_pkg::K_TOGGLE) begin
          pm_we = 1'b1; pm_wa = {grp_r, meas_r, st_i}; pm_wd = tog_row;
        end
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  logic [9:0] disp;
  logic [15:0] gates;
  always_comb begin
    disp = '0;
    if (song_st_r == dts_pkg::SONG_IDLE) disp = bpm;
    if (ext_mode_r) disp = '0;
    if (song_st_r == dts_pkg::SONG_REC) disp = 10'(song_len_r);
    if (song_st_r == dts_pkg::SONG_PLAY) disp = 10'(play_pos_r);
    for (int c = 0; c < 16; c++) gates[c] = cnt_r[c] != 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0;
      ext_mode_r <= 1'b0; ppb_r <= 24'd17896; trig_r <= 8'd50;
      song_len_r <= '0; play_pos_r <= '0; song_st_r <= dts_pkg::SONG_IDLE;
      loop_r <= 1'b0; run_r <= 1'b0; pend_r <= 1'b0; tempo_r <= 5'd23;
      phase_r <= 33'h100000000; tick_r <= 6'd47; step_r <= '0; wrap_r <= 4'd15;
      meas_r <= '0; grp_r <= '0; adv_r <= 1'b0; ld_r <= 1'b0; row_r <= '0;
      ov_valid_r <= 1'b0; inc_r <= '0;
      for (int c = 0; c < 16; c++) begin
        cnt_r[c] <= '0; copy_r[c] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      inc_r <= {24'd0, dts_pkg::bpm_of(tempo_nx)} * {10'd0, ppb_nx};
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          dts_pkg::CFG_EXT:   ext_mode_r <= cfg_data[0];
          dts_pkg::CFG_PHASE: ppb_r <= cfg_data;
          dts_pkg::CFG_TRIG:  trig_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      unique case (st_r)
        S_CLR: clr_r <= clr_r + 10'd1;
        S_IDLE: if (in_acc) begin
          it_r <= in_data; phase_r <= ph_n; tick_r <= tk_n; pend_r <= pd_n;
          adv_r <= adv_n; step_r <= step_in; play_pos_r <= pos_in;
        end
        S_RD: begin
          ld_r <= song_load;
          if (adv_r) begin
            for (int c = 0; c < 16; c++)
              if (pm_rd[c] && CH_MASK[c]) cnt_r[c] <= trig_r;
            if (step_r < wrap_r) step_r <= step_r + 4'd1;
            else step_r <= '0;
            play_pos_r <= pos_adv;
            if (song_end_stop) begin
              run_r <= 1'b0; song_st_r <= dts_pkg::SONG_IDLE;
            end
          end
        end
        S_EV: begin
          row_r <= '0;
          if (ld_r) begin
            meas_r <= sm_rd[3:0]; grp_r <= sm_rd[5:4];
          end
        end
        S_PAGE: begin
          row_r <= row_r + 5'd1;
          if (it_r.kind == dts_pkg::K_COPY && row_r != 5'd0)
            copy_r[row_r[3:0] - 4'd1] <= pm_rd;
        end
        S_DONE: begin
          // events that do not touch the pattern page
          case (it_r.kind)
            dts_pkg::K_MEASURE: if (it_r.button_index < 8'd16) meas_r <= it_r.button_index[3:0];
            dts_pkg::K_GROUP: if (it_r.button_index < 8'd4) grp_r <= it_r.button_index[1:0];
            dts_pkg::K_LAST: if (it_r.button_index < 8'd16) wrap_r <= it_r.button_index[3:0];
            dts_pkg::K_REC: song_st_r <= (song_st_r != dts_pkg::SONG_REC) ?
                                         dts_pkg::SONG_REC : dts_pkg::SONG_IDLE;
            dts_pkg::K_SONG: if (song_len_r != '0) begin
              if (song_st_r != dts_pkg::SONG_PLAY) begin
                song_st_r <= dts_pkg::SONG_PLAY; run_r <= 1'b1;
                play_pos_r <= '0; step_r <= '0;
                meas_r <= sm_rd[3:0]; grp_r <= sm_rd[5:4];
              end else begin
                song_st_r <= dts_pkg::SONG_IDLE; run_r <= 1'b0;
              end
            end
            dts_pkg::K_APPEND: if (song_st_r == dts_pkg::SONG_REC && song_len_r < LEN_MAX)
              song_len_r <= song_len_r + 1'b1;
            dts_pkg::K_REMOVE: if (song_st_r == dts_pkg::SONG_REC && song_len_r != '0)
              song_len_r <= song_len_r - 1'b1;
            dts_pkg::K_LOOP: loop_r <= !loop_r;
            dts_pkg::K_PLAY: if (!run_r) begin
              run_r <= 1'b1; step_r <= '0;
            end else begin
              run_r <= 1'b0;
              if (song_st_r == dts_pkg::SONG_PLAY) song_st_r <= dts_pkg::SONG_IDLE;
            end
            dts_pkg::K_FASTER: tempo_r <= tempo_nx;
            dts_pkg::K_SLOWER: tempo_r <= tempo_nx;
            default: ;
          endcase
        end
        default: ;
      endcase
      // result is built after S_DONE from the updated state, once the register is free
      if (res_wr) begin
        ov_valid_r <= 1'b1;
        ov_r.trigger_gates <= gates & CH_MASK;
        ov_r.step_pos <= step_r;
        ov_r.step_light_on <= run_r || ext_mode_r;
        ov_r.measure_sel <= meas_r;
        ov_r.group_sel <= grp_r;
        ov_r.last_step <= wrap_r;
        ov_r.song_mode <= song_st_r;
        ov_r.display_value <= disp;
        ov_r.running <= run_r;
        ov_r.loop_on <= loop_r;
        for (int c = 0; c < 16; c++)
          if (cnt_r[c] != 8'd0) cnt_r[c] <= cnt_r[c] - 8'd1;
      end else if (out_valid && out_ready) begin
        ov_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) it_pend_r <= 1'b0;
    else if (st_r == S_DONE) it_pend_r <= 1'b1;
    else if (res_wr) it_pend_r <= 1'b0;
  end

  assert property (@(posedge clk) disable iff (!rst_n) in_acc |=> st_r == S_RD)
    else $error("accepted item did not start");
  assert property (@(posedge clk) disable iff (!rst_n) st_r == S_CLR |-> !in_ready)
    else $error("item taken during clearing pass");
  assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_DONE |=> it_pend_r)
    else $error("finished item lost its result");
endmodule
